// File: src/vmc_pkg.sv
package vmc_pkg;

  localparam int LIMIT_BITS = 11;
  localparam int N_LANES    = 3;

endpackage

// File: src/vector_magnitude_clamp_3d.sv
// channel  | dir | tdata (low bit up)              | tuser
// in_      | in  | comp_x, comp_y, comp_z          | -
// out_     | out | out_x, out_y, out_z             | clamped
// cfg_     | in  | wr_data = max_magnitude         | -
// One item per cycle while out_tready allows, through stages a, b and c, the chain of
// COMP_BITS square-root cells, COMP_BITS divider cells and the output register.
// Reset clears all valid bits and sets max_magnitude to its maximum.
// The whole pipe holds while a result waits and out_tready is low.
module vector_magnitude_clamp_3d #(
  parameter int COMP_BITS = 24,
  parameter int FRAC_BITS = 12
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [((3*COMP_BITS+7)/8)*8-1:0]         in_tdata,   // comp_x, comp_y, comp_z
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  output logic [((3*COMP_BITS+7)/8)*8-1:0]         out_tdata,  // out_x, out_y, out_z
  output logic                                     out_tuser,  // clamped
  input  logic                                     cfg_wr_en,
  input  logic [vmc_pkg::LIMIT_BITS-1:0]           cfg_wr_data
);

  localparam int C      = COMP_BITS;
  localparam int LB     = vmc_pkg::LIMIT_BITS;
  localparam int NL     = vmc_pkg::N_LANES;
  localparam int DATA_W = ((3*C+7)/8)*8;
  localparam int SUM_W  = 2*C;
  localparam int LQ_W   = LB + FRAC_BITS;
  localparam int NUM_W  = C + LQ_W;
  localparam int CMP_W  = (SUM_W > 2*LQ_W) ? SUM_W : 2*LQ_W;
  localparam int SQ_SB  = 1 + NL*NUM_W + NL + NL*C;
  localparam int DV_SB  = 1 + NL + NL*C;

  logic                 en;
  logic [LB-1:0]        lim_r;
  logic [2*LB-1:0]      limsq_r;

  assign en        = out_tready | ~out_tvalid;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= {LB{1'b1}};
    end else if (cfg_wr_en) begin
      lim_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    limsq_r <= lim_r * lim_r;
  end

  // stage a: sign and magnitude
  logic                 va_r;
  logic [NL-1:0][C-1:0] raw_a_r, mag_a_r;
  logic [NL-1:0]        neg_a_r;
  logic [NL-1:0][C-1:0] raw_in;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      raw_in[i] = in_tdata[i*C +: C];
    end
  end

  // stage b: squares and magnitude times limit
  logic                    vb_r;
  logic [NL-1:0][C-1:0]    raw_b_r;
  logic [NL-1:0]           neg_b_r;
  logic [NL-1:0][SUM_W-1:0] sq_b_r;
  logic [NL-1:0][C+LB-1:0] prod_b_r;

  // stage c: sum and compare
  logic                    vc_r, clamp_c_r;
  logic [NL-1:0][C-1:0]    raw_c_r;
  logic [NL-1:0]           neg_c_r;
  logic [NL-1:0][C+LB-1:0] prod_c_r;
  logic [SUM_W-1:0]        sum_c_r, sum_nxt;
  logic                    clamp_nxt;

  always_comb begin
    sum_nxt   = sq_b_r[0] + sq_b_r[1] + sq_b_r[2];
    clamp_nxt = CMP_W'(sum_nxt) > CMP_W'({limsq_r, {(2*FRAC_BITS){1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_tvalid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NL; i++) begin
        raw_a_r[i]  <= raw_in[i];
        neg_a_r[i]  <= raw_in[i][C-1];
        mag_a_r[i]  <= raw_in[i][C-1] ? (~raw_in[i] + 1'b1) : raw_in[i];
        raw_b_r[i]  <= raw_a_r[i];
        neg_b_r[i]  <= neg_a_r[i];
        sq_b_r[i]   <= mag_a_r[i] * mag_a_r[i];
        prod_b_r[i] <= mag_a_r[i] * lim_r;
        raw_c_r[i]  <= raw_b_r[i];
        neg_c_r[i]  <= neg_b_r[i];
        prod_c_r[i] <= prod_b_r[i];
      end
      sum_c_r   <= sum_nxt;
      clamp_c_r <= clamp_nxt;
    end
  end

  // square-root chain
  logic [C:0]              sv;
  logic [C:0][SUM_W-1:0]   srad;
  logic [C:0][C+1:0]       srem;
  logic [C:0][C-1:0]       sroot;
  logic [C:0][SQ_SB-1:0]   sside;
  logic [NL-1:0][NUM_W-1:0] num_c;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      num_c[i] = {prod_c_r[i], {FRAC_BITS{1'b0}}};
    end
  end

  assign sv[0]    = vc_r;
  assign srad[0]  = sum_c_r;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign sside[0] = {clamp_c_r, num_c, neg_c_r, raw_c_r};

  for (genvar k = 0; k < C; k++) begin : g_sqrt
    vmc_sqrt_cell #(.RT_W(C), .SIDE_W(SQ_SB)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(sv[k]), .in_rad(srad[k]), .in_rem(srem[k]),
      .in_root(sroot[k]), .in_side(sside[k]),
      .out_valid(sv[k+1]), .out_rad(srad[k+1]), .out_rem(srem[k+1]),
      .out_root(sroot[k+1]), .out_side(sside[k+1])
    );
  end

  // divider chain
  logic                    s_clamp;
  logic [NL-1:0][NUM_W-1:0] s_num;
  logic [NL-1:0]           s_neg;
  logic [NL-1:0][C-1:0]    s_raw;

  assign {s_clamp, s_num, s_neg, s_raw} = sside[C];

  logic [C:0]                   dv;
  logic [C:0][C-1:0]            ddiv;
  logic [C:0][NL-1:0][C-1:0]    drem, dnum, dquo;
  logic [C:0][DV_SB-1:0]        dside;

  assign dv[0]    = sv[C];
  assign ddiv[0]  = sroot[C];
  assign dquo[0]  = '0;
  assign dside[0] = {s_clamp, s_neg, s_raw};

  for (genvar i = 0; i < NL; i++) begin : g_lane_in
    assign drem[0][i] = C'(s_num[i][NUM_W-1:C]);
    assign dnum[0][i] = s_num[i][C-1:0];
  end

  for (genvar k = 0; k < C; k++) begin : g_div
    vmc_div_cell #(.Q_W(C), .D_W(C), .SIDE_W(DV_SB)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(dv[k]), .in_div(ddiv[k]), .in_rem(drem[k]),
      .in_num(dnum[k]), .in_quo(dquo[k]), .in_side(dside[k]),
      .out_valid(dv[k+1]), .out_div(ddiv[k+1]), .out_rem(drem[k+1]),
      .out_num(dnum[k+1]), .out_quo(dquo[k+1]), .out_side(dside[k+1])
    );
  end

  // output register
  logic                 f_clamp;
  logic [NL-1:0]        f_neg;
  logic [NL-1:0][C-1:0] f_raw, res_nxt;
  logic                 ov_r, oclamp_r;
  logic [NL-1:0][C-1:0] ores_r;

  assign {f_clamp, f_neg, f_raw} = dside[C];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      if (!f_clamp) begin
        res_nxt[i] = f_raw[i];
      end else if (f_neg[i]) begin
        res_nxt[i] = ~dquo[C][i] + 1'b1;
      end else begin
        res_nxt[i] = dquo[C][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= dv[C];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ores_r   <= res_nxt;
      oclamp_r <= f_clamp;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = DATA_W'(ores_r);
  assign out_tuser  = oclamp_r;

endmodule

// File: src/vmc_sqrt_cell.sv
module vmc_sqrt_cell #(
  parameter int RT_W   = 24,
  parameter int SIDE_W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2*RT_W-1:0]   in_rad,
  input  logic [RT_W+1:0]     in_rem,
  input  logic [RT_W-1:0]     in_root,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [2*RT_W-1:0]   out_rad,
  output logic [RT_W+1:0]     out_rem,
  output logic [RT_W-1:0]     out_root,
  output logic [SIDE_W-1:0]   out_side
);

  logic                valid_r;
  logic [2*RT_W-1:0]   rad_r, rad_nxt;
  logic [RT_W+1:0]     rem_r, rem_nxt, cur, trial;
  logic [RT_W-1:0]     root_r, root_nxt;
  logic [SIDE_W-1:0]   side_r;

  // one root bit per cell: bring in the next two radicand bits and try root*4+1
  always_comb begin
    cur   = {in_rem[RT_W-1:0], in_rad[2*RT_W-1 -: 2]};
    trial = {in_root, 2'b01};
    rad_nxt = {in_rad[2*RT_W-3:0], 2'b00};
    if (cur >= trial) begin
      rem_nxt  = cur - trial;
      root_nxt = {in_root[RT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = cur;
      root_nxt = {in_root[RT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rad   = rad_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_side  = side_r;

endmodule

// File: src/vmc_div_cell.sv
module vmc_div_cell #(
  parameter int Q_W    = 24,
  parameter int D_W    = 24,
  parameter int SIDE_W = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [D_W-1:0]                         in_div,
  input  logic [vmc_pkg::N_LANES-1:0][D_W-1:0]   in_rem,
  input  logic [vmc_pkg::N_LANES-1:0][Q_W-1:0]   in_num,
  input  logic [vmc_pkg::N_LANES-1:0][Q_W-1:0]   in_quo,
  input  logic [SIDE_W-1:0]                      in_side,
  output logic                                   out_valid,
  output logic [D_W-1:0]                         out_div,
  output logic [vmc_pkg::N_LANES-1:0][D_W-1:0]   out_rem,
  output logic [vmc_pkg::N_LANES-1:0][Q_W-1:0]   out_num,
  output logic [vmc_pkg::N_LANES-1:0][Q_W-1:0]   out_quo,
  output logic [SIDE_W-1:0]                      out_side
);

  logic                                   valid_r;
  logic [D_W-1:0]                         div_r;
  logic [vmc_pkg::N_LANES-1:0][D_W-1:0]   rem_r, rem_nxt;
  logic [vmc_pkg::N_LANES-1:0][Q_W-1:0]   num_r, num_nxt, quo_r, quo_nxt;
  logic [SIDE_W-1:0]                      side_r;
  logic [D_W:0]                           t;

  // one quotient bit per cell in each lane, restoring
  always_comb begin
    for (int i = 0; i < vmc_pkg::N_LANES; i++) begin
      t          = {in_rem[i], in_num[i][Q_W-1]};
      num_nxt[i] = {in_num[i][Q_W-2:0], 1'b0};
      if (t >= {1'b0, in_div}) begin
        rem_nxt[i] = D_W'(t - {1'b0, in_div});
        quo_nxt[i] = {in_quo[i][Q_W-2:0], 1'b1};
      end else begin
        rem_nxt[i] = t[D_W-1:0];
        quo_nxt[i] = {in_quo[i][Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r  <= in_div;
      rem_r  <= rem_nxt;
      num_r  <= num_nxt;
      quo_r  <= quo_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_div   = div_r;
  assign out_rem   = rem_r;
  assign out_num   = num_r;
  assign out_quo   = quo_r;
  assign out_side  = side_r;

endmodule
